[design/pbs_pkg.sv]
`timescale 1ns / 1ps

package pbs_pkg;

   localparam int FRAME_BYTES = 65536;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int MEAN_W      = 8;
   localparam int SPREAD_W    = 17;
   localparam int DIV_W       = 8;
   localparam int SIGMA_W     = 4;
   localparam int CSR_DATA_W  = 8;

   // reciprocal of the divisor, scaled by 2^RECIP_SHIFT and rounded up
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   localparam logic [MEAN_W-1:0]   MEAN_RESET    = MEAN_W'(128);
   localparam logic [SPREAD_W-1:0] SPREAD_MAX    = {SPREAD_W{1'b1}};
   localparam logic [DIV_W-1:0]    DIVISOR_RESET = DIV_W'(5);
   localparam logic [SIGMA_W-1:0]  SIGMA_RESET   = SIGMA_W'(3);

   typedef enum logic [0:0] {
      CSR_DIVISOR = 1'b0,
      CSR_SIGMA   = 1'b1
   } csr_index_type;

endpackage

[design/pixel_background_subtraction.sv]
`timescale 1ns / 1ps

// pipeline: s1, s2, s3, s4, output register; mean read-modify-write closes in s1 with forwarding
// throughput: one pixel per cycle when not busy and the result is not held by rsp_stall
// reset: all 65536 mean memory entries are swept to 128, one per cycle, req stalled meanwhile
// a divisor write (and reset) recomputes the divisor reciprocal, req stalled until it is done
// registers reset to divisor 5 and sigma multiple 3
module pixel_background_subtraction (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [15:0]                       req_pixel_index,
   input  logic [7:0]                        req_pixel_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_foreground,
   output logic [7:0]                        rsp_background_mean,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  pbs_pkg::csr_index_type            csr_index,
   input  logic [pbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pbs_pkg::*;

   // configuration
   logic [DIV_W-1:0]   divisor_ff;
   logic [SIGMA_W-1:0] sigma_ff;
   logic [2*SIGMA_W-1:0] k2_ff;         // sigma squared, registered
   logic [DIV_W-1:0]   n_eff;           // divisor zero acts as one
   logic               csr_wr;
   logic               recip_start_ff;
   logic               recip_busy;
   logic [RECIP_W-1:0] recip;

   // memory clearing sweep
   logic               clear_ff;
   logic [ADDR_W-1:0]  clear_addr_ff;
   logic               busy;

   // pipeline control
   logic advance;
   logic accept;

   // mean memory, read data registered at accept
   logic [MEAN_W-1:0] mean_mem [FRAME_BYTES];
   logic [MEAN_W-1:0] rd_ff;

   // stage s1: mean update
   logic               s1_v_ff;
   logic [ADDR_W-1:0]  s1_idx_ff;
   logic [7:0]         s1_val_ff;
   logic [MEAN_W-1:0]  old_mean;
   logic [MEAN_W+RECIP_W-1:0] prod_old, prod_val;
   logic [MEAN_W:0]    mean_sum;
   logic [MEAN_W-1:0]  new_mean;
   logic               fwd;

   // stage s2: differences and squares
   logic               s2_v_ff;
   logic [ADDR_W-1:0]  s2_idx_ff;
   logic [7:0]         s2_val_ff;
   logic [MEAN_W-1:0]  s2_old_ff, s2_mean_ff;
   logic [MEAN_W-1:0]  delta, diff;
   logic [2*MEAN_W-1:0] dd, lhs;

   // stage s3: spread
   logic               s3_v_ff;
   logic [MEAN_W-1:0]  s3_mean_ff;
   logic [2*MEAN_W-1:0] s3_dd_ff, s3_lhs_ff;
   logic [DIV_W+2*MEAN_W-1:0] spread_full;
   logic [SPREAD_W-1:0] spread;

   // stage s4: threshold test
   logic               s4_v_ff;
   logic [MEAN_W-1:0]  s4_mean_ff;
   logic [2*MEAN_W-1:0] s4_lhs_ff;
   logic [SPREAD_W-1:0] s4_spread_ff;
   logic [2*SIGMA_W+SPREAD_W-1:0] rhs;

   // output register
   logic               out_v_ff;
   logic               out_fg_ff;
   logic [MEAN_W-1:0]  out_mean_ff;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign n_eff     = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff     <= DIVISOR_RESET;
         sigma_ff       <= SIGMA_RESET;
         recip_start_ff <= 1'b1;
      end else begin
         recip_start_ff <= 1'b0;
         if (csr_wr) begin
            unique case (csr_index)
               CSR_DIVISOR: begin
                  divisor_ff     <= csr_wdata[DIV_W-1:0];
                  recip_start_ff <= 1'b1;
               end
               CSR_SIGMA: sigma_ff <= csr_wdata[SIGMA_W-1:0];
               default: ;
            endcase
         end
      end
      k2_ff <= (2*SIGMA_W)'(sigma_ff) * (2*SIGMA_W)'(sigma_ff);
   end

   // reciprocal of the divisor, so that m / n becomes a multiply and shift
   pbs_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start_ff),
      .divisor (n_eff),
      .busy    (recip_busy),
      .recip   (recip)
   );

   // ---------------- clearing sweep ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == {ADDR_W{1'b1}}) begin
            clear_ff <= 1'b0;
         end
      end
   end

   assign busy = clear_ff || recip_start_ff || recip_busy;

   // ---------------- handshake ----------------
   // the whole pipe moves as one; it holds only when the result waits
   assign advance   = !out_v_ff || !rsp_stall;
   assign req_stall = !advance || busy;
   assign accept    = req_valid && !req_stall;

   // ---------------- mean memory ----------------
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mean_mem[clear_addr_ff] <= MEAN_RESET;
      end else if (advance && s1_v_ff) begin
         mean_mem[s1_idx_ff] <= new_mean;
      end
      if (accept) begin
         rd_ff <= mean_mem[req_pixel_index[ADDR_W-1:0]];
      end
   end

   // ---------------- s1: mean update ----------------
   // the beat just ahead wrote on the edge this one read, so take its mean directly
   assign fwd      = s2_v_ff && (s2_idx_ff == s1_idx_ff);
   assign old_mean = fwd ? s2_mean_ff : rd_ff;
   // exact truncating quotient for 8-bit dividend: (m * ceil(2^16/n)) >> 16
   assign prod_old = (MEAN_W+RECIP_W)'(old_mean) * (MEAN_W+RECIP_W)'(recip);
   assign prod_val = (MEAN_W+RECIP_W)'(s1_val_ff) * (MEAN_W+RECIP_W)'(recip);
   assign mean_sum = (MEAN_W+1)'(old_mean)
                   - (MEAN_W+1)'(prod_old[RECIP_SHIFT +: MEAN_W])
                   + (MEAN_W+1)'(prod_val[RECIP_SHIFT +: MEAN_W]);
   assign new_mean = mean_sum[MEAN_W] ? {MEAN_W{1'b1}} : mean_sum[MEAN_W-1:0];

   // ---------------- s2: differences and squares ----------------
   assign delta = (s2_mean_ff >= s2_old_ff) ? s2_mean_ff - s2_old_ff : s2_old_ff - s2_mean_ff;
   assign diff  = (s2_val_ff >= s2_mean_ff) ? s2_val_ff - s2_mean_ff : s2_mean_ff - s2_val_ff;
   assign dd    = (2*MEAN_W)'(delta) * (2*MEAN_W)'(delta);
   assign lhs   = (2*MEAN_W)'(diff) * (2*MEAN_W)'(diff);

   // ---------------- s3: spread = n * delta^2, saturated ----------------
   assign spread_full = (DIV_W+2*MEAN_W)'(n_eff) * (DIV_W+2*MEAN_W)'(s3_dd_ff);
   assign spread = (spread_full > (DIV_W+2*MEAN_W)'(SPREAD_MAX)) ? SPREAD_MAX
                 : spread_full[SPREAD_W-1:0];

   // ---------------- s4: diff^2 > k^2 * spread ----------------
   // a positive diff follows from lhs > rhs since rhs is never negative
   assign rhs = (2*SIGMA_W+SPREAD_W)'(k2_ff) * (2*SIGMA_W+SPREAD_W)'(s4_spread_ff);

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff  <= accept;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         out_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff    <= req_pixel_index[ADDR_W-1:0];
         s1_val_ff    <= req_pixel_value;
         s2_idx_ff    <= s1_idx_ff;
         s2_val_ff    <= s1_val_ff;
         s2_old_ff    <= old_mean;
         s2_mean_ff   <= new_mean;
         s3_mean_ff   <= s2_mean_ff;
         s3_dd_ff     <= dd;
         s3_lhs_ff    <= lhs;
         s4_mean_ff   <= s3_mean_ff;
         s4_lhs_ff    <= s3_lhs_ff;
         s4_spread_ff <= spread;
         out_mean_ff  <= s4_mean_ff;
         out_fg_ff    <= (2*SIGMA_W+SPREAD_W)'(s4_lhs_ff) > rhs;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_is_foreground   = out_fg_ff;
   assign rsp_background_mean = out_mean_ff;

   // ---------------- assertions ----------------
   // no beat enters during the sweep or while the reciprocal is rebuilt
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("beat accepted while busy");

   // reciprocal is the rounded-up 2^16 / n once settled
   a_recip_exact: assert property (@(posedge clock) disable iff (reset)
      !busy |-> ((25'(recip) * 25'(n_eff) >= 25'(1 << RECIP_SHIFT))
                 && (25'(recip) * 25'(n_eff) - 25'(1 << RECIP_SHIFT) < 25'(n_eff))))
      else $error("divisor reciprocal out of range");

   // a held pipe keeps its beats
   a_hold_s1: assert property (@(posedge clock) disable iff (reset)
      !advance && s1_v_ff |=> s1_v_ff)
      else $error("stage s1 beat lost while held");

   // no memory write while the sweep runs
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_v_ff)
      else $error("pixel beat in pipe during sweep");

endmodule

[design/pbs_recip.sv]
`timescale 1ns / 1ps

// restoring divider: recip = ceil(2^RECIP_SHIFT / divisor), one bit per cycle
module pbs_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pbs_pkg::DIV_W-1:0]     divisor,
   output logic                          busy,
   output logic [pbs_pkg::RECIP_W-1:0]   recip
);
   import pbs_pkg::*;

   localparam int CNT_W = $clog2(RECIP_W);

   logic [RECIP_W-1:0] num_ff, num_in;
   logic [RECIP_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [DIV_W:0]     rem_sh;
   logic [DIV_W:0]     rem_sub;
   logic               ge;

   assign rem_sh  = {rem_ff, num_ff[RECIP_W-1]};
   assign ge      = rem_sh >= {1'b0, divisor};
   assign rem_sub = rem_sh - {1'b0, divisor};

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(divisor) - RECIP_W'(1);
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[RECIP_W-2:0], 1'b0};
         quo_in = {quo_ff[RECIP_W-2:0], ge};
         rem_in = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(RECIP_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;

endmodule

[sim/pixel_background_subtraction_tb.sv]
`timescale 1ns / 1ps

module pixel_background_subtraction_tb;
   import pbs_pkg::*;

   // expected response of one pixel beat
   typedef struct {
      logic       fg;
      logic [7:0] mean;
   } pixel_verdict_type;

   // mirror of the per-pixel running mean plus the two registers
   class pixel_scoreboard;
      logic [7:0]     mean_mirror [FRAME_BYTES];
      logic [7:0]     divisor;
      logic [3:0]     sigma_k;
      pixel_verdict_type pending [$];
      int             mismatches;

      function void clear();
         foreach (mean_mirror[i]) mean_mirror[i] = MEAN_RESET;
         divisor = DIVISOR_RESET;
         sigma_k = SIGMA_RESET;
         pending.delete();
         mismatches = 0;
      endfunction

      // register write as the block sees it
      function void note_csr(csr_index_type idx, logic [7:0] data);
         if (idx == CSR_DIVISOR) divisor = data;
         else sigma_k = data[3:0];
      endfunction

      // mean update, spread and threshold test for one accepted pixel
      function void note_pixel(logic [15:0] idx, logic [7:0] val);
         int unsigned    n, old_m, new_m, delta, diff;
         longint unsigned spread, lhs, rhs;
         pixel_verdict_type v;
         n      = (divisor == 0) ? 1 : divisor;
         old_m  = mean_mirror[idx];
         new_m  = old_m - old_m / n + val / n;
         if (new_m > 255) new_m = 255;
         delta  = (new_m >= old_m) ? new_m - old_m : old_m - new_m;
         spread = longint'(n) * delta * delta;
         if (spread > SPREAD_MAX) spread = SPREAD_MAX;
         mean_mirror[idx] = new_m[7:0];
         diff   = (val >= new_m) ? val - new_m : new_m - val;
         lhs    = longint'(diff) * diff;
         rhs    = longint'(sigma_k) * sigma_k * spread;
         v.fg   = (diff > 0) && (lhs > rhs);
         v.mean = new_m[7:0];
         pending.push_back(v);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic fg, logic [7:0] mean);
         pixel_verdict_type v;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result fg=%0b mean=%0d", fg, mean));
            return;
         end
         v = pending.pop_front();
         if (fg !== v.fg)
            report($sformatf("is_foreground got %0b want %0b", fg, v.fg));
         if (mean !== v.mean)
            report($sformatf("background_mean got %0d want %0d", mean, v.mean));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [15:0]   req_pixel_index = '0;
   logic [7:0]    req_pixel_value = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_is_foreground;
   logic [7:0]    rsp_background_mean;
   logic          csr_valid = 1'b0;
   csr_index_type csr_index = CSR_DIVISOR;
   logic [7:0]    csr_wdata = '0;
   logic          csr_ready;

   pixel_scoreboard sb = new();

   // traffic shaping knobs; steady_flow is shared by sender and receiver
   bit steady_flow;     // no gaps on either side
   int rsp_hold_cycles; // one long receiver hold-off when nonzero

   always #5 clock = ~clock;

   pixel_background_subtraction i_dut (.*);

   // receiver: random stall, maybe none, before each result; a set long hold-off replaces it once
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = steady_flow ? 0 : $urandom_range(0, 11);
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (reset || !rsp_valid);
         sb.check_result(rsp_is_foreground, rsp_background_mean);
         @(negedge clock);
      end
   end

   // one pixel beat with a random leading gap; valid stays high between back-to-back beats
   task send_pixel(logic [15:0] idx, logic [7:0] val);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_index <= idx;
      req_pixel_value <= val;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(idx, val);
      @(negedge clock);
   endtask

   // drain the pipe, then let the block settle before touching registers
   task wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // valid stays high between back-to-back writes; the caller drops it
   task write_csr(csr_index_type idx, logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_csr(idx, data);
      @(negedge clock);
   endtask

   task set_registers(logic [7:0] div, logic [3:0] k);
      wait_drained();
      write_csr(CSR_DIVISOR, div);
      // sigma only keeps the low nibble, upper bits are noise
      write_csr(CSR_SIGMA, {4'($urandom), k});
      csr_valid <= 1'b0;
   endtask

   // mostly a small pool of pixels so means evolve, rest anywhere in the frame
   task random_pixels(int count);
      logic [15:0] idx;
      logic [7:0]  val;
      repeat (count) begin
         case ($urandom_range(0, 9)) inside
            [0:1]:   idx = 16'($urandom);
            2:       idx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: idx = 16'($urandom_range(0, 15));
         endcase
         // values near the current mean exercise the background side of the test
         if ($urandom_range(0, 2) == 0)
            val = sb.mean_mirror[idx] + 8'($urandom_range(0, 6)) - 8'd3;
         else
            val = 8'($urandom);
         send_pixel(idx, val);
      end
   endtask

   typedef struct {
      logic [7:0] div;
      logic [3:0] k;
   } reg_setting_type;

   initial begin
      reg_setting_type settings [$];
      sb.clear();
      steady_flow = 1'b0;
      rsp_hold_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset registers, field extremes, same pixel back to back
      send_pixel(16'h0000, 8'h00);
      send_pixel(16'hFFFF, 8'hFF);
      send_pixel(16'h0000, 8'h00);
      send_pixel(16'h0000, 8'hFF);
      send_pixel(16'h0001, 8'd128);
      send_pixel(16'h0001, 8'd128);
      send_pixel(16'h5AA5, 8'hA5);
      send_pixel(16'hA55A, 8'h5A);

      // divisor zero behaves as one, sigma zero makes any difference foreground
      set_registers(8'd0, 4'd0);
      send_pixel(16'h0002, 8'd7);
      send_pixel(16'h0002, 8'd7);
      send_pixel(16'h0003, 8'd128);
      set_registers(8'd1, 4'd0);
      send_pixel(16'h0002, 8'd200);
      send_pixel(16'h0003, 8'd129);
      set_registers(8'd255, 4'd15);
      send_pixel(16'h0004, 8'hFF);
      send_pixel(16'h0004, 8'h00);
      send_pixel(16'hFFFF, 8'h00);

      // pressure: long receiver hold-off while beats keep coming with no gaps
      set_registers(8'd4, 4'd2);
      steady_flow = 1'b1;
      rsp_hold_cycles = 150;
      random_pixels(40);
      steady_flow = 1'b0;

      settings = '{'{8'd5, 4'd3}, '{8'd1, 4'd1}, '{8'd255, 4'd15}, '{8'd0, 4'd0},
                   '{8'd2, 4'd1}, '{8'd8, 4'd4}, '{8'd3, 4'd0}, '{8'd16, 4'd2},
                   '{8'd128, 4'd7}, '{8'd6, 4'd15}};
      foreach (settings[i]) begin
         set_registers(settings[i].div, settings[i].k);
         // one stretch in three without idling on either side
         steady_flow = ($urandom_range(0, 2) == 0);
         random_pixels(35);
         steady_flow = 1'b0;
         random_pixels(35);
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // guard against a hung handshake; reset sweep alone covers all 65536 mean entries
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
